>>> rtl/core/gibs_pkg.sv
// Shared types, constants and helpers for the glyph ink bounds scan unit.
// No dependencies; every other file imports this package.
package gibs_pkg;

  // Sheet and glyph limits
  localparam int GLYPH_COUNT        = 256;
  localparam int GLYPH_AW           = $clog2(GLYPH_COUNT);
  localparam int MAX_TILE_SIZE      = 64;
  localparam int MAX_TILES_PER_SIDE = 16;
  localparam int REFERENCE_GLYPH    = 65;

  // Field widths
  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 7;
  localparam int TILES_W = 5;
  localparam int SPACE_W = 8;
  localparam int INDEX_W = 8;
  localparam int INTILE_W = $clog2(MAX_TILE_SIZE);
  localparam int TCOL_W   = $clog2(MAX_TILES_PER_SIDE);
  localparam int EDGE_W   = 2 * COORD_W;

  // Tile divider sizes (glyph index over tiles per row)
  localparam int DIV_NW = INDEX_W;
  localparam int DIV_DW = TILES_W;
  localparam int DIV_CW = $clog2(DIV_NW);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_PRESET = 3'd5;

  // Item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [PIX_W-1:0]     pixel;
    logic [INDEX_W-1:0]   glyph_index;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]   glyph_x;
    logic [COORD_W-1:0]   glyph_y;
    logic [SIZE_W-1:0]    glyph_width;
    logic [SIZE_W-1:0]    glyph_height;
    logic [SIZE_W-1:0]    line_step;
    logic [SPACE_W-1:0]   space_width;
    logic                 scan_complete;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NW-1:0]    dividend;
    logic [DIV_DW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NW-1:0]    quotient;
    logic [DIV_DW-1:0]    remainder;
  } div_rsp_t;

  // Clamp a tile size register to 1..MAX_TILE_SIZE
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(MAX_TILE_SIZE)) r = SIZE_W'(MAX_TILE_SIZE);
    else r = v;
    return r;
  endfunction

  // Clamp a tile count register to 1..MAX_TILES_PER_SIDE
  function automatic logic [TILES_W-1:0] clamp_tiles(input logic [TILES_W-1:0] v);
    logic [TILES_W-1:0] r;
    if (v == '0) r = TILES_W'(1);
    else if (v > TILES_W'(MAX_TILES_PER_SIDE)) r = TILES_W'(MAX_TILES_PER_SIDE);
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/core/gibs_divider.sv
// Restoring divider, one quotient bit per cycle, for glyph index / tiles across.
// Depends on gibs_pkg for widths and the request/response structs.
module gibs_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  gibs_pkg::div_req_t req,
  output gibs_pkg::div_rsp_t rsp
);
  import gibs_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quot_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] div_r;

  logic [DIV_DW:0]   trial;
  logic              fits;
  logic [DIV_DW-1:0] rem_nxt;

  // One restoring step
  always_comb begin
    trial   = {rem_r, quot_r[DIV_NW-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? DIV_DW'(trial - {1'b0, div_r}) : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= !req.start && busy_r && (cnt_r == DIV_CW'(DIV_NW - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quot_r <= req.dividend;
        rem_r  <= '0;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        quot_r <= {quot_r[DIV_NW-2:0], fits};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_NW - 1)) busy_r <= 1'b0;
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quot_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/core/glyph_ink_bounds_scan_unit.sv
// Top level of the glyph ink bounds scan: raster counters, edge memory, read path.
// Depends on gibs_pkg and gibs_divider.
//
// Pixels of a font sheet arrive in raster order (mode 0) and update, per glyph
// tile, the leftmost and rightmost inked columns held in a 256-entry edge
// memory; a read item (mode 1) returns the glyph's trimmed rectangle together
// with the line step, space width and scan-complete flag. A pixel passes through
// accept, edge memory read and write-back, set by the read-modify-write
// on the edge memory. A read passes through accept, the eight-step tile
// row/column divider and a multiply step before the result, plus any
// wait for the result register to drain; a pixel may be accepted while a
// result is still waiting. Writing a geometry or key color register restarts
// the scan and holds off input until the restart is done; ink flags live
// in flip-flops and clear at once, so no clearing pass runs after reset.
module glyph_ink_bounds_scan_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gibs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gibs_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gibs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gibs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gibs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PIX_RD, S_PIX_WR, S_RD_DIV, S_RD_MUL, S_RD_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [SIZE_W-1:0]  tile_width_r, tile_height_r;
  logic [TILES_W-1:0] tiles_across_r, tiles_down_r;
  logic [PIX_W-1:0]   key_color_r;
  logic [SPACE_W-1:0] space_preset_r;
  logic               restart_r;

  // Scan state
  logic [COORD_W-1:0]  pixel_column_r, pixel_row_r;
  logic [INTILE_W-1:0] col_in_tile_r, row_in_tile_r;
  logic [TCOL_W-1:0]   tile_col_r;
  logic [GLYPH_AW:0]   row_base_r;
  logic [GLYPH_COUNT-1:0] ink_seen_r;
  logic [SIZE_W-1:0]   common_top_r, reference_bottom_r;
  logic                done_r;

  // Item payload
  logic [PIX_W-1:0]    pixel_r;
  logic [GLYPH_AW:0]   glyph_r;
  logic [INDEX_W-1:0]  g_r;
  logic [DIV_NW-1:0]   trow_r;
  logic [DIV_DW-1:0]   tcol_r;
  logic [COORD_W-1:0]  tile_x_r, tile_y_r;
  logic                in_range_r;

  // Edge memory: {left, right} per glyph
  logic [EDGE_W-1:0]   edge_mem [GLYPH_COUNT];
  logic [EDGE_W-1:0]   rdata_r;
  logic                mem_re, mem_we;
  logic [GLYPH_AW-1:0] mem_raddr, mem_waddr;
  logic [EDGE_W-1:0]   mem_wdata;

  // Output register
  logic                out_valid_r;
  out_item_t           out_data_r;

  // Effective geometry
  logic [SIZE_W-1:0]  eff_tw, eff_th;
  logic [TILES_W-1:0] eff_ta, eff_td;
  logic [COORD_W:0]   sheet_w, sheet_h;
  logic [2*TILES_W-1:0] tile_total;

  always_comb begin
    eff_tw     = clamp_size(tile_width_r);
    eff_th     = clamp_size(tile_height_r);
    eff_ta     = clamp_tiles(tiles_across_r);
    eff_td     = clamp_tiles(tiles_down_r);
    sheet_w    = (COORD_W+1)'(eff_tw * eff_ta);
    sheet_h    = (COORD_W+1)'(eff_th * eff_td);
    tile_total = eff_ta * eff_td;
  end

  // Handshake
  logic in_acc, cfg_acc, out_free, do_restart;
  assign in_ready  = (state_r == S_IDLE) && !restart_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign do_restart = ((state_r == S_IDLE) && restart_r)
                    || (in_acc && (in_data.mode == MODE_PIXEL) && done_r);

  // Tile divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req.start    = in_acc && (in_data.mode == MODE_READ);
  assign div_req.dividend = in_data.glyph_index;
  assign div_req.divisor  = eff_ta;

  gibs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Pixel update
  logic [GLYPH_AW:0]  glyph_nxt;
  logic               hit;
  logic               seen;
  logic [COORD_W-1:0] left_old, right_old, left_nxt, right_nxt;
  logic               tile_end, row_end, intile_row_end, sheet_end;

  always_comb begin
    glyph_nxt = row_base_r + (GLYPH_AW+1)'(tile_col_r);
    hit       = (glyph_r < (GLYPH_AW+1)'(GLYPH_COUNT)) && (pixel_r != key_color_r);
    seen      = ink_seen_r[glyph_r[GLYPH_AW-1:0]];
    left_old  = rdata_r[EDGE_W-1:COORD_W];
    right_old = rdata_r[COORD_W-1:0];
    if (!seen) begin
      left_nxt  = pixel_column_r;
      right_nxt = pixel_column_r;
    end else begin
      left_nxt  = (pixel_column_r < left_old)  ? pixel_column_r : left_old;
      right_nxt = (pixel_column_r > right_old) ? pixel_column_r : right_old;
    end
    tile_end       = ({1'b0, col_in_tile_r} + SIZE_W'(1)) == eff_tw;
    row_end        = ({1'b0, pixel_column_r} + (COORD_W+1)'(1)) == sheet_w;
    intile_row_end = ({1'b0, row_in_tile_r} + SIZE_W'(1)) == eff_th;
    sheet_end      = ({1'b0, pixel_row_r} + (COORD_W+1)'(1)) == sheet_h;
  end

  // Memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = glyph_nxt[GLYPH_AW-1:0];
    if (in_acc && (in_data.mode == MODE_READ)) begin
      mem_re    = 1'b1;
      mem_raddr = in_data.glyph_index[GLYPH_AW-1:0];
    end else if (state_r == S_PIX_RD) begin
      mem_re = 1'b1;
    end
    mem_we    = (state_r == S_PIX_WR) && hit;
    mem_waddr = glyph_r[GLYPH_AW-1:0];
    mem_wdata = {left_nxt, right_nxt};
  end

  always_ff @(posedge clk) begin
    if (mem_we) edge_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= edge_mem[mem_raddr];
  end

  // Read result assembly
  out_item_t          rd_item;
  logic               rd_ink;
  logic [COORD_W-1:0] ink_w;
  logic [COORD_W:0]   y_sum;

  always_comb begin
    rd_ink = ink_seen_r[g_r[GLYPH_AW-1:0]];
    ink_w  = right_old - left_old + COORD_W'(1);
    y_sum  = {1'b0, tile_y_r} + (COORD_W+1)'(common_top_r);
    rd_item = '0;
    if (in_range_r) begin
      rd_item.glyph_x      = rd_ink ? left_old : tile_x_r;
      rd_item.glyph_width  = rd_ink ? ink_w[SIZE_W-1:0] : eff_tw;
      rd_item.glyph_y      = y_sum[COORD_W] ? {COORD_W{1'b1}} : y_sum[COORD_W-1:0];
      rd_item.glyph_height = eff_th - common_top_r;
    end
    rd_item.line_step     = reference_bottom_r - common_top_r;
    rd_item.space_width   = (space_preset_r != '0) ? space_preset_r
                                                   : SPACE_W'(eff_tw[SIZE_W-1:1]);
    rd_item.scan_complete = done_r;
  end

  // Payload captured without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pixel_r <= in_data.pixel;
      g_r     <= in_data.glyph_index;
    end
    if (state_r == S_PIX_RD) glyph_r <= glyph_nxt;
    if (div_rsp.done) begin
      trow_r <= div_rsp.quotient;
      tcol_r <= div_rsp.remainder;
    end
    if (state_r == S_RD_MUL) begin
      tile_x_r   <= COORD_W'(tcol_r * eff_tw);
      tile_y_r   <= COORD_W'(trow_r * eff_th);
      in_range_r <= ({2'b00, g_r} < tile_total)
                    && ({1'b0, g_r} < (INDEX_W+1)'(GLYPH_COUNT));
    end
    if ((state_r == S_RD_OUT) && out_free) out_data_r <= rd_item;
  end

  // Control, configuration and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      tile_width_r       <= SIZE_W'(8);
      tile_height_r      <= SIZE_W'(8);
      tiles_across_r     <= TILES_W'(16);
      tiles_down_r       <= TILES_W'(16);
      key_color_r        <= '0;
      space_preset_r     <= '0;
      restart_r          <= 1'b0;
      pixel_column_r     <= '0;
      pixel_row_r        <= '0;
      col_in_tile_r      <= '0;
      row_in_tile_r      <= '0;
      tile_col_r         <= '0;
      row_base_r         <= '0;
      ink_seen_r         <= '0;
      common_top_r       <= SIZE_W'(8);
      reference_bottom_r <= SIZE_W'(8);
      done_r             <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      // output register loads a finished read, drains on transfer
      if ((state_r == S_RD_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      // scan restart
      if (do_restart) begin
        pixel_column_r     <= '0;
        pixel_row_r        <= '0;
        col_in_tile_r      <= '0;
        row_in_tile_r      <= '0;
        tile_col_r         <= '0;
        row_base_r         <= '0;
        ink_seen_r         <= '0;
        common_top_r       <= eff_th;
        reference_bottom_r <= eff_th;
        done_r             <= 1'b0;
      end

      // configuration writes
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_TILE_WIDTH:   tile_width_r   <= cfg_data[SIZE_W-1:0];
          CFG_TILE_HEIGHT:  tile_height_r  <= cfg_data[SIZE_W-1:0];
          CFG_TILES_ACROSS: tiles_across_r <= cfg_data[TILES_W-1:0];
          CFG_TILES_DOWN:   tiles_down_r   <= cfg_data[TILES_W-1:0];
          CFG_KEY_COLOR:    key_color_r    <= cfg_data[PIX_W-1:0];
          CFG_SPACE_PRESET: space_preset_r <= cfg_data[SPACE_W-1:0];
          default: ;
        endcase
      end
      if (cfg_acc && (cfg_index inside {CFG_TILE_WIDTH, CFG_TILE_HEIGHT, CFG_TILES_ACROSS,
                                         CFG_TILES_DOWN, CFG_KEY_COLOR})) begin
        restart_r <= 1'b1;
      end else if ((state_r == S_IDLE) && restart_r) begin
        restart_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (in_data.mode == MODE_PIXEL) ? S_PIX_RD : S_RD_DIV;
          end
        end
        S_PIX_RD: begin
          state_r <= S_PIX_WR;
        end
        S_PIX_WR: begin
          // record ink
          if (hit) begin
            ink_seen_r[glyph_r[GLYPH_AW-1:0]] <= 1'b1;
            if ({1'b0, row_in_tile_r} < common_top_r) begin
              common_top_r <= SIZE_W'(row_in_tile_r);
            end
            if (glyph_r == (GLYPH_AW+1)'(REFERENCE_GLYPH)) begin
              reference_bottom_r <= SIZE_W'(row_in_tile_r);
            end
          end
          // advance raster position
          if (row_end) begin
            pixel_column_r <= '0;
            col_in_tile_r  <= '0;
            tile_col_r     <= '0;
            if (sheet_end) begin
              pixel_row_r   <= '0;
              row_in_tile_r <= '0;
              row_base_r    <= '0;
              done_r        <= 1'b1;
            end else begin
              pixel_row_r <= pixel_row_r + COORD_W'(1);
              if (intile_row_end) begin
                row_in_tile_r <= '0;
                row_base_r    <= row_base_r + (GLYPH_AW+1)'(eff_ta);
              end else begin
                row_in_tile_r <= row_in_tile_r + INTILE_W'(1);
              end
            end
          end else begin
            pixel_column_r <= pixel_column_r + COORD_W'(1);
            if (tile_end) begin
              col_in_tile_r <= '0;
              tile_col_r    <= tile_col_r + TCOL_W'(1);
            end else begin
              col_in_tile_r <= col_in_tile_r + INTILE_W'(1);
            end
          end
          state_r <= S_IDLE;
        end
        S_RD_DIV: begin
          if (div_rsp.done) state_r <= S_RD_MUL;
        end
        S_RD_MUL: begin
          state_r <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/gibs_checker.sv
// Port-level checks for the glyph ink bounds scan unit, bound to the top level.
// Depends on gibs_pkg for the item structs and register indexes.
module gibs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input gibs_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input gibs_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [gibs_pkg::CFG_IDX_W-1:0]  cfg_index
);
  import gibs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // a pixel transfer blocks input in the next cycle, during the edge read-modify-write
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_PIXEL) |=> !in_ready)
    else $error("input taken during edge read-modify-write");

  // a geometry or key write restarts the scan before any item
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == CFG_TILE_WIDTH || cfg_index == CFG_TILE_HEIGHT
      || cfg_index == CFG_TILES_ACROSS || cfg_index == CFG_TILES_DOWN
      || cfg_index == CFG_KEY_COLOR) |=> !in_ready)
    else $error("input taken before scan restart");

  // glyph sizes never exceed the largest tile size
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.glyph_width <= SIZE_W'(MAX_TILE_SIZE))
               && (out_data.glyph_height <= SIZE_W'(MAX_TILE_SIZE)))
    else $error("glyph size beyond tile size");

endmodule

bind glyph_ink_bounds_scan_unit gibs_checker u_gibs_checker (.*);
